>>> design/cpwm_pkg.sv
// ----------------------------------------------------------------------------
// cpwm_pkg
// Shared types and constants of the current power window min/max block.
// ----------------------------------------------------------------------------
package cpwm_pkg;

   // field widths
   localparam int SampleWidth  = 12;
   localparam int PowerWidth   = 12;
   localparam int WordWidth    = 16;
   localparam int CountWidth   = 16;
   localparam int ProductWidth = 32;
   localparam int GainShift    = 20;
   localparam int AddrWidth    = 4;
   localparam int DataWidth    = 32;

   typedef logic [SampleWidth-1:0]  sample_type;
   typedef logic [PowerWidth-1:0]   power_type;
   typedef logic [WordWidth-1:0]    word_type;
   typedef logic [CountWidth-1:0]   count_type;
   typedef logic [ProductWidth-1:0] product_type;

   // configuration register file contents
   typedef struct packed {
      word_type  zero_offset;
      word_type  watts_gain;
      power_type over_threshold;
      count_type window_length;
   } cfg_type;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_ZERO_OFFSET    = 2'd0,
      REG_WATTS_GAIN     = 2'd1,
      REG_OVER_THRESHOLD = 2'd2,
      REG_WINDOW_LENGTH  = 2'd3
   } reg_index_type;

   // reset values
   localparam word_type  RstZeroOffset    = 16'd32689;
   localparam word_type  RstWattsGain     = 16'd52798;
   localparam power_type RstOverThreshold = 12'd100;
   localparam count_type RstWindowLength  = 16'd1000;

   localparam count_type CountMax = '1;

endpackage

>>> design/cpwm_if.sv
// ----------------------------------------------------------------------------
// cpwm_req_if / cpwm_rsp_if
// Valid/ready channels carrying samples in and power results out.
// ----------------------------------------------------------------------------
interface cpwm_req_if;
   import cpwm_pkg::*;

   logic       valid;
   logic       ready;
   sample_type adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface cpwm_rsp_if;
   import cpwm_pkg::*;

   logic      valid;
   logic      ready;
   power_type power_watts;
   logic      window_done;
   power_type window_min;
   power_type window_max;
   count_type over_count;

   modport source (output valid, output power_watts, output window_done,
                   output window_min, output window_max, output over_count,
                   input ready);
   modport sink   (input valid, input power_watts, input window_done,
                   input window_min, input window_max, input over_count,
                   output ready);
endinterface

>>> design/cpwm_csr.sv
// ----------------------------------------------------------------------------
// cpwm_csr
// APB-style configuration registers: offset, gain, threshold, window length.
// ----------------------------------------------------------------------------
module cpwm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cpwm_pkg::AddrWidth-1:0] paddr,
   input  logic [cpwm_pkg::DataWidth-1:0] pwdata,
   output logic [cpwm_pkg::DataWidth-1:0] prdata,
   output logic                          pready,
   output cpwm_pkg::cfg_type             cfg
);
   import cpwm_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_index;
   logic          write_en;

   assign reg_index = reg_index_type'(paddr[AddrWidth-1:2]);
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // write the selected register in the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_offset    <= RstZeroOffset;
         cfg_ff.watts_gain     <= RstWattsGain;
         cfg_ff.over_threshold <= RstOverThreshold;
         cfg_ff.window_length  <= RstWindowLength;
      end else if (write_en) begin
         case (reg_index)
            REG_ZERO_OFFSET:    cfg_ff.zero_offset    <= pwdata[WordWidth-1:0];
            REG_WATTS_GAIN:     cfg_ff.watts_gain     <= pwdata[WordWidth-1:0];
            REG_OVER_THRESHOLD: cfg_ff.over_threshold <= pwdata[PowerWidth-1:0];
            REG_WINDOW_LENGTH:  cfg_ff.window_length  <= pwdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // read back, zero extended
   always_comb begin
      case (reg_index)
         REG_ZERO_OFFSET:    prdata = DataWidth'(cfg_ff.zero_offset);
         REG_WATTS_GAIN:     prdata = DataWidth'(cfg_ff.watts_gain);
         REG_OVER_THRESHOLD: prdata = DataWidth'(cfg_ff.over_threshold);
         REG_WINDOW_LENGTH:  prdata = DataWidth'(cfg_ff.window_length);
         default:            prdata = '0;
      endcase
   end

endmodule

>>> design/cpwm_power.sv
// ----------------------------------------------------------------------------
// cpwm_power
// First stage: offset removal and gain multiply into the product register.
// ----------------------------------------------------------------------------
module cpwm_power (
   input  logic                   clock,
   input  logic                   reset,
   cpwm_req_if.sink               req,
   input  cpwm_pkg::cfg_type      cfg,
   output logic                   prod_valid,
   input  logic                   prod_ready,
   output cpwm_pkg::product_type  product
);
   import cpwm_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   product_type product_ff;
   product_type product_in;
   word_type    scaled;
   word_type    diff;
   logic        take;

   assign req.ready  = !valid_ff || prod_ready;
   assign take       = req.valid && req.ready;
   assign prod_valid = valid_ff;
   assign product    = product_ff;

   // magnitude of the offset-corrected sample, times the gain
   always_comb begin
      scaled = {req.adc_sample, 4'b0000};
      if (scaled >= cfg.zero_offset) begin
         diff = scaled - cfg.zero_offset;
      end else begin
         diff = cfg.zero_offset - scaled;
      end
      product_in = ProductWidth'(diff) * ProductWidth'(cfg.watts_gain);
   end

   // hold the stage while the next one stalls
   assign valid_in = take || (valid_ff && !prod_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         product_ff <= product_in;
      end
   end

endmodule

>>> design/cpwm_window.sv
// ----------------------------------------------------------------------------
// cpwm_window
// Second stage: window min/max tracking, over-threshold count, result register.
// ----------------------------------------------------------------------------
module cpwm_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  prod_valid,
   output logic                  prod_ready,
   input  cpwm_pkg::product_type product,
   input  cpwm_pkg::cfg_type     cfg,
   cpwm_rsp_if.source            rsp
);
   import cpwm_pkg::*;

   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      done_ff;
   logic      done_in;
   power_type prev_power_ff;
   count_type fill_count_ff;
   count_type fill_count_in;
   power_type run_min_ff;
   power_type run_min_in;
   power_type run_max_ff;
   power_type run_max_in;
   power_type pub_min_ff;
   power_type pub_min_in;
   power_type pub_max_ff;
   power_type pub_max_in;
   count_type over_count_ff;
   count_type over_count_in;
   count_type count_base;
   logic      over;
   logic      take;

   // state registers double as the result payload: they only move on a take,
   // and a take only happens once the previous result has left or is leaving
   assign prod_ready      = !rsp_valid_ff || rsp.ready;
   assign take            = prod_valid && prod_ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.power_watts = prev_power_ff;
   assign rsp.window_done = done_ff;
   assign rsp.window_min  = pub_min_ff;
   assign rsp.window_max  = pub_max_ff;
   assign rsp.over_count  = over_count_ff;

   // store the previous power into the window, or close the window
   always_comb begin
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      pub_min_in    = pub_min_ff;
      pub_max_in    = pub_max_ff;
      fill_count_in = fill_count_ff;
      done_in       = 1'b0;
      if (fill_count_ff < cfg.window_length) begin
         if (fill_count_ff == '0) begin
            run_min_in = prev_power_ff;
            run_max_in = prev_power_ff;
         end else begin
            if (prev_power_ff < run_min_ff) run_min_in = prev_power_ff;
            if (prev_power_ff > run_max_ff) run_max_in = prev_power_ff;
         end
         fill_count_in = fill_count_ff + 1'b1;
      end else begin
         pub_min_in    = run_min_ff;
         pub_max_in    = run_max_ff;
         fill_count_in = '0;
         done_in       = 1'b1;
      end
   end

   // count samples over threshold, saturating
   always_comb begin
      over          = product > {cfg.over_threshold, {GainShift{1'b0}}};
      count_base    = done_in ? '0 : over_count_ff;
      over_count_in = count_base;
      if (over && (count_base != CountMax)) begin
         over_count_in = count_base + 1'b1;
      end
   end

   assign rsp_valid_in = take || (rsp_valid_ff && !rsp.ready);

   // control and reset-defined state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         prev_power_ff <= '0;
         fill_count_ff <= '0;
         pub_min_ff    <= '0;
         pub_max_ff    <= '0;
         over_count_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            prev_power_ff <= product[ProductWidth-1:GainShift];
            fill_count_ff <= fill_count_in;
            pub_min_ff    <= pub_min_in;
            pub_max_ff    <= pub_max_in;
            over_count_ff <= over_count_in;
         end
      end
   end

   // running extremes and the done flag
   always_ff @(posedge clock) begin
      if (take) begin
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
         done_ff    <= done_in;
      end
   end

endmodule

>>> design/current_power_window_minmax.sv
// ----------------------------------------------------------------------------
// current_power_window_minmax
// Current-sensor power conversion with windowed min/max and over counting.
// ----------------------------------------------------------------------------
// Accepts one sample transaction every clock cycle while the result channel
// does not stall. Each sample passes the gain multiply register and then the
// window/result register before its result goes valid. Backpressure on the
// result channel stalls both stages without losing transactions. Write the
// configuration registers only while no transaction is in flight.
module current_power_window_minmax (
   input  logic                          clock,
   input  logic                          reset,
   cpwm_req_if.sink                      req_chan,
   cpwm_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cpwm_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [cpwm_pkg::DataWidth-1:0] csr_pwdata,
   output logic [cpwm_pkg::DataWidth-1:0] csr_prdata,
   output logic                          csr_pready
);
   import cpwm_pkg::*;

   cfg_type     cfg;
   logic        prod_valid;
   logic        prod_ready;
   product_type product;

   // configuration registers
   cpwm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // offset and gain multiply
   cpwm_power u_power (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .product    (product)
   );

   // window tracking and result register
   cpwm_window u_window (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .product    (product),
      .cfg        (cfg),
      .rsp        (rsp_chan)
   );

endmodule

>>> tb/current_power_window_minmax_tb.sv
// ----------------------------------------------------------------------------
// current_power_window_minmax_tb
// Self-checking bench for the current power window min/max block.
// ----------------------------------------------------------------------------
// Samples go in over the request channel and power results come back over the
// response channel. Both sides idle at random. A local tracker of the
// conversion, window and over-count logic predicts every result. Each result
// is compared field by field with the oldest prediction. Configuration is
// written over APB, and read back, only while no transaction is in flight.
// The directed tests cover field extremes, short and empty windows, a window
// shortened mid-way, and a long window counting back to back. Random phases
// with varied settings follow.
module current_power_window_minmax_tb;
   import cpwm_pkg::*;

   typedef struct {
      power_type power_watts;
      logic      window_done;
      power_type window_min;
      power_type window_max;
      count_type over_count;
   } power_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [AddrWidth-1:0] csr_paddr;
   logic [DataWidth-1:0] csr_pwdata;
   logic [DataWidth-1:0] csr_prdata;
   logic                 csr_pready;

   cpwm_req_if req_bus ();
   cpwm_rsp_if rsp_bus ();

   current_power_window_minmax uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // tracker state: shadow registers and window state
   cfg_type   csr_shadow;
   power_type prev_power;
   count_type fill_count;
   power_type run_min;
   power_type run_max;
   power_type pub_min;
   power_type pub_max;
   count_type over_counter;
   bit        running_valid;

   power_result_type power_results_due[$];
   int unsigned      mismatch_count;
   bit               idling;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // bail out if the run hangs
   initial begin
      #5_000_000;
      $display("** current_power_window_minmax: FAILED **");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (mismatch_count < 40)
         $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic reset_tracker();
      csr_shadow.zero_offset    = RstZeroOffset;
      csr_shadow.watts_gain     = RstWattsGain;
      csr_shadow.over_threshold = RstOverThreshold;
      csr_shadow.window_length  = RstWindowLength;
      prev_power    = '0;
      fill_count    = '0;
      run_min       = '0;
      run_max       = '0;
      pub_min       = '0;
      pub_max       = '0;
      over_counter  = '0;
      running_valid = 1'b0;
   endtask

   // Advance the window with the previous power, then convert this sample.
   function automatic power_result_type track_sample(input sample_type s);
      power_result_type r;
      word_type         scaled;
      word_type         diff;
      product_type      product;
      scaled = {s, 4'b0000};
      r.window_done = 1'b0;
      if (fill_count < csr_shadow.window_length) begin
         if (fill_count == '0) begin
            run_min = prev_power;
            run_max = prev_power;
         end else begin
            if (prev_power < run_min) run_min = prev_power;
            if (prev_power > run_max) run_max = prev_power;
         end
         fill_count    = fill_count + 1'b1;
         running_valid = 1'b1;
      end else begin
         pub_min       = run_min;
         pub_max       = run_max;
         fill_count    = '0;
         over_counter  = '0;
         r.window_done = 1'b1;
      end
      diff = (scaled >= csr_shadow.zero_offset) ? scaled - csr_shadow.zero_offset
                                                : csr_shadow.zero_offset - scaled;
      product = product_type'(diff) * product_type'(csr_shadow.watts_gain);
      // product stays below 2^32, so the top twelve bits never need clamping
      prev_power = product[ProductWidth-1:GainShift];
      if (product > (product_type'(csr_shadow.over_threshold) << GainShift) &&
          over_counter != CountMax)
         over_counter = over_counter + 1'b1;
      r.power_watts = prev_power;
      r.window_min  = pub_min;
      r.window_max  = pub_max;
      r.over_count  = over_counter;
      return r;
   endfunction

   // Write one register, read it back, update the shadow copy.
   task automatic write_csr(input reg_index_type idx, input logic [DataWidth-1:0] value);
      logic [DataWidth-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (csr_pready !== 1'b1);
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (csr_pready !== 1'b1);
      readback = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value) report_mismatch("register readback", readback, value);
      case (idx)
         REG_ZERO_OFFSET:    csr_shadow.zero_offset    = value[WordWidth-1:0];
         REG_WATTS_GAIN:     csr_shadow.watts_gain     = value[WordWidth-1:0];
         REG_OVER_THRESHOLD: csr_shadow.over_threshold = value[PowerWidth-1:0];
         REG_WINDOW_LENGTH:  csr_shadow.window_length  = value[CountWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all_csrs(input word_type offset, input word_type gain,
                                 input power_type threshold, input count_type length);
      write_csr(REG_ZERO_OFFSET, DataWidth'(offset));
      write_csr(REG_WATTS_GAIN, DataWidth'(gain));
      write_csr(REG_OVER_THRESHOLD, DataWidth'(threshold));
      write_csr(REG_WINDOW_LENGTH, DataWidth'(length));
   endtask

   // Send one sample transaction; returns just after the accepting edge.
   task automatic send_sample(input sample_type s);
      int unsigned gap;
      gap = idling ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.adc_sample <= s;
      power_results_due.push_back(track_sample(s));
      do @(negedge clock); while (req_bus.ready !== 1'b1);
      @(posedge clock);
   endtask

   // Drop valid and wait for every pending result, flagging any left over.
   task automatic wait_idle();
      int unsigned cycles;
      cycles = 0;
      req_bus.valid <= 1'b0;
      while (power_results_due.size() != 0 && cycles < 200) begin
         @(posedge clock);
         cycles++;
      end
      if (power_results_due.size() != 0) begin
         report_mismatch("results never returned", 0, power_results_due.size());
         power_results_due.delete();
      end
   endtask

   // Draw a sample: extremes, full range, or close to the zero level.
   function automatic sample_type pick_sample();
      int v;
      case ($urandom_range(0, 5))
         0: v = 0;
         1: v = 4095;
         2: begin
            v = int'(csr_shadow.zero_offset >> 4) + $urandom_range(0, 6) - 3;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
         end
         default: v = $urandom_range(0, 4095);
      endcase
      return sample_type'(v);
   endfunction

   // Accept result transactions with random stalls and check each one.
   initial begin : result_checker
      power_result_type got;
      power_result_type want;
      int unsigned      stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = idling ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(negedge clock); while (rsp_bus.valid !== 1'b1);
         got.power_watts = rsp_bus.power_watts;
         got.window_done = rsp_bus.window_done;
         got.window_min  = rsp_bus.window_min;
         got.window_max  = rsp_bus.window_max;
         got.over_count  = rsp_bus.over_count;
         @(posedge clock);
         if (power_results_due.size() == 0) begin
            report_mismatch("result with nothing pending, power", got.power_watts, 0);
         end else begin
            want = power_results_due.pop_front();
            if (got.power_watts !== want.power_watts)
               report_mismatch("power_watts", got.power_watts, want.power_watts);
            if (got.window_done !== want.window_done)
               report_mismatch("window_done", got.window_done, want.window_done);
            if (got.window_min !== want.window_min)
               report_mismatch("window_min", got.window_min, want.window_min);
            if (got.window_max !== want.window_max)
               report_mismatch("window_max", got.window_max, want.window_max);
            if (got.over_count !== want.over_count)
               report_mismatch("over_count", got.over_count, want.over_count);
         end
      end
   end

   // Reset configuration: sample extremes, alternating bits, around zero level.
   task automatic test_reset_config_extremes();
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'hAAA);
      send_sample(12'h555);
      send_sample(12'd2043);
      send_sample(12'd2044);
      send_sample(12'd1);
      send_sample(12'd4094);
      wait_idle();
   endtask

   // Windows of one, empty windows, and a window shortened part way through.
   task automatic test_short_windows();
      write_all_csrs(16'd0, 16'd65535, 12'd0, 16'd1);
      repeat (4) send_sample(sample_type'($urandom_range(0, 4095)));
      wait_idle();
      // every sample closes a window and republishes the held min/max
      write_csr(REG_WINDOW_LENGTH, 32'd0);
      repeat (3) send_sample(sample_type'($urandom_range(0, 4095)));
      wait_idle();
      write_csr(REG_WINDOW_LENGTH, 32'd5);
      repeat (4) send_sample(sample_type'($urandom_range(0, 4095)));
      wait_idle();
      // fill count now above the new length: next sample closes
      write_csr(REG_WINDOW_LENGTH, 32'd2);
      repeat (2) send_sample(sample_type'($urandom_range(0, 4095)));
      wait_idle();
   endtask

   // Largest product, top threshold, and a zero product against threshold zero.
   task automatic test_gain_extremes();
      write_all_csrs(16'd65535, 16'd65535, 12'd4095, 16'd3);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd1);
      wait_idle();
      write_all_csrs(16'd32688, 16'd0, 12'd0, 16'd4);
      send_sample(12'd4095);
      wait_idle();
      write_csr(REG_WATTS_GAIN, 32'd65535);
      send_sample(12'd2043);
      wait_idle();
   endtask

   // Run one long window back to back with every sample over threshold.
   task automatic test_long_window();
      idling = 1'b0;
      write_all_csrs(16'd0, 16'd65535, 12'd0, 16'd0);
      send_sample(12'd1000);
      wait_idle();
      write_csr(REG_WINDOW_LENGTH, 32'd65535);
      repeat (150) send_sample(sample_type'($urandom_range(1, 4095)));
      wait_idle();
      idling = 1'b1;
   endtask

   // Random settings per phase, random samples within each.
   task automatic test_random_phases();
      word_type  offset;
      word_type  gain;
      power_type threshold;
      count_type length;
      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 4))
            0: offset = 16'd0;
            1: offset = 16'd65535;
            2: offset = RstZeroOffset;
            default: offset = word_type'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 4))
            0: gain = 16'd0;
            1: gain = 16'd65535;
            default: gain = word_type'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 4))
            0: threshold = 12'd0;
            1: threshold = 12'd4095;
            2: threshold = power_type'($urandom_range(0, 4095));
            default: threshold = power_type'($urandom_range(0, 300));
         endcase
         case ($urandom_range(0, 9))
            0: length = 16'd1;
            1: length = 16'd65535;
            2: length = running_valid ? 16'd0 : 16'd1;
            3, 4, 5: length = count_type'($urandom_range(1, 8));
            default: length = count_type'($urandom_range(2, 60));
         endcase
         idling = ($urandom_range(0, 3) != 0);
         write_all_csrs(offset, gain, threshold, length);
         repeat (100) send_sample(pick_sample());
         wait_idle();
      end
      idling = 1'b1;
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.adc_sample <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      mismatch_count = 0;
      idling         = 1'b1;
      reset_tracker();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config_extremes();
      test_short_windows();
      test_gain_extremes();
      test_long_window();
      test_random_phases();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("** current_power_window_minmax: PASSED **");
      else
         $display("** current_power_window_minmax: FAILED **");
      $finish;
   end

endmodule
